// File: rtl/infix_to_postfix_converter_defines.svh
// Assertion macros used by the checker file of the infix to postfix converter.
// No dependencies.
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// same-cycle implication, off during reset
`define ITP_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define ITP_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/itp_pkg.sv
// Package for the infix to postfix converter: constants, word types, level function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

    localparam int ITP_STACK_DEPTH = 16;
    localparam int ITP_IQ_DEPTH    = 2;
    localparam int ITP_OQ_DEPTH    = 4;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;

    typedef enum logic [1:0] {
        CLS_LETTER,
        CLS_LPAREN,
        CLS_RPAREN,
        CLS_OP
    } cls_t;

    typedef enum logic [1:0] {
        PH_MAIN,
        PH_FLUSH,
        PH_FIN
    } phase_t;

    typedef struct packed {
        logic [7:0] sym;
        cls_t       cls;
        logic [1:0] lvl;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [7:0] sym;
        logic       has;
        logic       last;
        logic       ovf;
    } res_t;

    function automatic logic [1:0] itp_level(input logic [7:0] ch);
        logic [1:0] lv;
        lv = 2'd0;
        if (ch == CH_PLUS || ch == CH_MINUS)
        begin
            lv = 2'd1;
        end
        else if (ch == CH_STAR || ch == CH_SLASH)
        begin
            lv = 2'd2;
        end
        return lv;
    endfunction

endpackage

`default_nettype wire

// File: rtl/itp_fifo.sv
// Small register queue, used between front and back and on the result side.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module itp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/itp_front.sv
// Front end: classifies each input character and queues it for the back end.
// Depends on itp_pkg and itp_fifo.
`timescale 1ns / 1ps
`default_nettype none

module itp_front
    import itp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] symbol,
    input  wire logic       end_of_expr,
    output item_t           head,
    output logic            head_vld,
    input  wire logic       head_rd
);

    item_t                     item_in;
    logic [$bits(item_t)-1:0]  rd_bits;
    logic                      q_empty;

    always_comb
    begin
        item_in.sym  = symbol;
        item_in.lvl  = itp_level(symbol);
        item_in.last = end_of_expr;
        if (symbol inside {[CH_UC_A:CH_UC_Z], [CH_LC_A:CH_LC_Z]})
        begin
            item_in.cls = CLS_LETTER;
        end
        else if (symbol == CH_LPAREN)
        begin
            item_in.cls = CLS_LPAREN;
        end
        else if (symbol == CH_RPAREN)
        begin
            item_in.cls = CLS_RPAREN;
        end
        else
        begin
            item_in.cls = CLS_OP;
        end
    end

    itp_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (ITP_IQ_DEPTH)
    ) u_iq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (item_in),
        .full    (full),
        .rd_en   (head_rd),
        .rd_data (rd_bits),
        .empty   (q_empty)
    );

    assign head     = item_t'(rd_bits);
    assign head_vld = !q_empty;

endmodule

`default_nettype wire

// File: rtl/itp_back.sv
// Back end: operator stack and pop sequencer; holds one result back to tag the last.
// Depends on itp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itp_back
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = ITP_STACK_DEPTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire item_t head,
    input  wire logic  head_vld,
    output logic       head_rd,
    output logic       out_wr,
    output res_t       out_word,
    input  wire logic  out_full
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    logic [7:0]       stk_reg [STACK_DEPTH];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    phase_t           phase_reg, phase_next;
    logic             stage_vld_reg, stage_vld_next;
    logic [7:0]       stage_sym_reg, stage_sym_next;
    logic             drop_reg, drop_next;

    logic             step, push_en, pop_en, emit, fin, post;
    logic [7:0]       emit_sym;
    logic             stk_nonempty, stk_full;
    logic [1:0]       top_lvl;

    assign step         = head_vld && !out_full;
    assign stk_nonempty = (cnt_reg != '0);
    assign stk_full     = (cnt_reg == CNT_W'(STACK_DEPTH));
    assign top_lvl      = itp_level(stk_reg[0]);

    always_comb
    begin
        push_en        = 1'b0;
        pop_en         = 1'b0;
        emit           = 1'b0;
        emit_sym       = stk_reg[0];
        fin            = 1'b0;
        post           = 1'b0;
        drop_next      = drop_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        stage_vld_next = stage_vld_reg;
        stage_sym_next = stage_sym_reg;
        head_rd        = 1'b0;
        out_wr         = 1'b0;
        out_word       = '{sym: stage_sym_reg, has: 1'b1, last: 1'b0, ovf: 1'b0};

        if (step)
        begin
            case (phase_reg)
                PH_MAIN:
                begin
                    case (head.cls)
                        CLS_LETTER:
                        begin
                            emit     = 1'b1;
                            emit_sym = head.sym;
                            post     = 1'b1;
                        end
                        CLS_LPAREN:
                        begin
                            if (stk_full)
                                drop_next = 1'b1;
                            else
                                push_en = 1'b1;
                            post = 1'b1;
                        end
                        CLS_RPAREN:
                        begin
                            if (stk_nonempty && stk_reg[0] != CH_LPAREN)
                            begin
                                pop_en = 1'b1;
                                emit   = 1'b1;
                            end
                            else
                            begin
                                pop_en = stk_nonempty;
                                post   = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (stk_nonempty && top_lvl >= head.lvl)
                            begin
                                pop_en = 1'b1;
                                emit   = 1'b1;
                            end
                            else
                            begin
                                if (stk_full)
                                    drop_next = 1'b1;
                                else
                                    push_en = 1'b1;
                                post = 1'b1;
                            end
                        end
                    endcase
                    if (post)
                        phase_next = head.last ? PH_FLUSH : PH_FIN;
                end
                PH_FLUSH:
                begin
                    if (stk_nonempty)
                    begin
                        pop_en = 1'b1;
                        emit   = 1'b1;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
                default:
                begin
                    fin = 1'b1;
                end
            endcase

            if (push_en)
                cnt_next = cnt_reg + CNT_W'(1);
            else if (pop_en)
                cnt_next = cnt_reg - CNT_W'(1);

            if (emit)
            begin
                out_wr         = stage_vld_reg;
                stage_vld_next = 1'b1;
                stage_sym_next = emit_sym;
            end

            if (fin)
            begin
                out_wr         = stage_vld_reg || head.last || drop_reg;
                out_word.sym   = stage_vld_reg ? stage_sym_reg : 8'd0;
                out_word.has   = stage_vld_reg;
                out_word.last  = 1'b1;
                out_word.ovf   = drop_reg;
                stage_vld_next = 1'b0;
                drop_next      = 1'b0;
                head_rd        = 1'b1;
                phase_next     = PH_MAIN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_MAIN;
            cnt_reg       <= '0;
            stage_vld_reg <= 1'b0;
            drop_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            stage_vld_reg <= stage_vld_next;
            drop_reg      <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_sym_reg <= stage_sym_next;
        if (push_en)
        begin
            stk_reg[0] <= head.sym;
            for (int i = 1; i < STACK_DEPTH; i++)
            begin
                stk_reg[i] <= stk_reg[i-1];
            end
        end
        else if (pop_en)
        begin
            for (int i = 0; i < STACK_DEPTH - 1; i++)
            begin
                stk_reg[i] <= stk_reg[i+1];
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/infix_to_postfix_converter.sv
// Infix to postfix converter (shunting yard), top level.
// Depends on itp_pkg, itp_front, itp_back and itp_fifo.
//
// Input channel: one character per word with an end-of-expression flag, taken
// when push is high and full is low. Result channel: one postfix word per pop
// while empty is low; has_symbol low marks a bare end or overflow report, and
// last_of_run / overflow ride on the last word caused by each character.
// A character passes the input queue, the operator stack sequencer and a
// one-word staging register on its way to the result queue; one word is held
// back so the last word of a character is written when its sequencing ends.
// The sequencer takes a character through a main step, a pop step per emitted
// operator and a finishing step before the next; it waits on a full result queue.
// A two-word input queue and a four-word result queue decouple both sides;
// when the receiver stalls the sequencer waits and the input queue fills.
// Reset empties both queues and the operator stack; stack contents are not
// cleared, the entry count is.
// A push to a full stack is dropped and reported with overflow.
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = ITP_STACK_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] symbol,
    input  wire logic       end_of_expr,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      out_symbol,
    output logic            has_symbol,
    output logic            last_of_run,
    output logic            overflow
);

    item_t                    head;
    logic                     head_vld, head_rd;
    logic                     res_wr, res_full;
    res_t                     res_word, res_head;
    logic [$bits(res_t)-1:0]  res_bits;

    itp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .symbol      (symbol),
        .end_of_expr (end_of_expr),
        .head        (head),
        .head_vld    (head_vld),
        .head_rd     (head_rd)
    );

    itp_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .head_vld (head_vld),
        .head_rd  (head_rd),
        .out_wr   (res_wr),
        .out_word (res_word),
        .out_full (res_full)
    );

    itp_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (ITP_OQ_DEPTH)
    ) u_oq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res_word),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_bits),
        .empty   (empty)
    );

    assign res_head    = res_t'(res_bits);
    assign out_symbol  = res_head.sym;
    assign has_symbol  = res_head.has;
    assign last_of_run = res_head.last;
    assign overflow    = res_head.ovf;

endmodule

`default_nettype wire

// File: rtl/itp_checker.sv
// Port-level checks for the infix to postfix converter, bound to the top level.
// Depends on infix_to_postfix_converter_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "infix_to_postfix_converter_defines.svh"

module itp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       push,
    input wire logic       full,
    input wire logic [7:0] symbol,
    input wire logic       end_of_expr,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] out_symbol,
    input wire logic       has_symbol,
    input wire logic       last_of_run,
    input wire logic       overflow
);

    `ITP_ASSERT_IMP(a_bare_is_last, clk, rst_n, (!empty && !has_symbol), last_of_run, "bare word not last")
    `ITP_ASSERT_IMP(a_ovf_is_last, clk, rst_n, (!empty && overflow), last_of_run, "overflow not on last word")
    `ITP_ASSERT_IMP(a_bare_zero, clk, rst_n, (!empty && !has_symbol), (out_symbol == 8'd0), "bare word carries a symbol")
    `ITP_ASSERT_NXT(a_hold, clk, rst_n, (!empty && !pop), (!empty && $stable(out_symbol) && $stable(last_of_run)), "result changed while stalled")

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (.*);

`default_nettype wire
